// ===== rtl/core/spectral_peak_interpolator_assert.svh =====
// Assertion macros used by the spectral peak interpolator top level.
`ifndef SPECTRAL_PEAK_INTERPOLATOR_ASSERT_SVH
`define SPECTRAL_PEAK_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPI_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("spectral_peak_interpolator: assertion failed");

// next-cycle implication, disabled during reset
`define SPI_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("spectral_peak_interpolator: assertion failed");

`endif

// ===== rtl/core/spi_pkg.sv =====
// Shared constants, types and state encoding for the spectral peak interpolator.
`default_nettype none

package spi_pkg;

	localparam int MAX_VECTOR_LEN_DEF = 1024;
	localparam int SAMPLE_WIDTH_DEF   = 16;

	localparam int VLEN_W = 11;
	localparam logic [VLEN_W-1:0] VLEN_RESET = 11'd1024;

	localparam int PEAK_BIN_W  = 10;
	localparam int OFFSET_W    = 16;
	localparam int OUT_TDATA_W = ((PEAK_BIN_W + OFFSET_W + 7) / 8) * 8;

	// Q2.13 scaled by two more for round-half-up: floor((N*2^14 + D) / 2D)
	localparam int FRAC_SHIFT = 14;
	// quotient bits; the top bit only flags overflow into saturation
	localparam int QUO_W = OFFSET_W + 1;
	localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(1) << (OFFSET_W - 1);
	localparam logic [QUO_W-1:0] POS_LIMIT = NEG_LIMIT - QUO_W'(1);
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
	localparam logic [OFFSET_W-1:0] OFFSET_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};

	localparam int JOB_FIFO_DEPTH = 2;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DIFF,
		B_MUL_DD,
		B_MUL_II,
		B_MUL_ND,
		B_MUL_NI,
		B_COMB,
		B_PREP,
		B_DIV,
		B_DONE
	} back_state_t;

	typedef struct packed {
		logic                  offset_forced_zero;
		logic [OFFSET_W-1:0]   frac_offset;
		logic [PEAK_BIN_W-1:0] peak_bin;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/spi_job_fifo.sv =====
// Small register FIFO carrying per-vector peak jobs from front to back.
`default_nettype none

module spi_job_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = spi_pkg::JOB_FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/spi_front.sv =====
// Front end: squares each bin, tracks the peak and its neighbors, emits one job per vector.
`default_nettype none

module spi_front #(
	parameter int MAX_VECTOR_LEN = spi_pkg::MAX_VECTOR_LEN_DEF,
	parameter int SAMPLE_WIDTH   = spi_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [spi_pkg::VLEN_W-1:0]       vector_len,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]   in_re,
	input  logic signed [SAMPLE_WIDTH-1:0]   in_im,
	output logic                             job_push,
	// {edge, peak index, right, peak, left}; each sample is {im, re}
	output logic [6*SAMPLE_WIDTH+$clog2(MAX_VECTOR_LEN):0] job_data,
	input  logic                             job_full
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int BW    = $clog2(MAX_VECTOR_LEN);
	localparam int CW    = (BW + 1 > spi_pkg::VLEN_W) ? BW + 1 : spi_pkg::VLEN_W;
	localparam int PW    = 2 * SW;
	localparam int CPX_W = 2 * SW;
	localparam logic [CW-1:0] MAX_LEN = CW'(MAX_VECTOR_LEN);

	// stage 1: sample and its squared parts
	logic                 v_s1;
	logic signed [SW-1:0] re_s1;
	logic signed [SW-1:0] im_s1;
	logic [PW-1:0]        pre_s1;
	logic [PW-1:0]        pim_s1;

	// per-vector tracking state
	logic [BW-1:0]    cnt_q;
	logic [BW-1:0]    bidx_q;
	logic [PW-1:0]    best_q;
	logic [CPX_W-1:0] prev_q;
	logic [CPX_W-1:0] left_q;
	logic [CPX_W-1:0] peak_q;
	logic [CPX_W-1:0] right_q;
	logic             rpend_q;

	logic signed [PW-1:0] sq_re;
	logic signed [PW-1:0] sq_im;
	logic [PW-1:0]        pw;
	logic [CPX_W-1:0]     cur;
	logic [CW-1:0]        len_raw;
	logic [CW-1:0]        len_eff;
	logic [CW-1:0]        cnt_inc;
	logic                 is_last;
	logic                 take;
	logic                 commit;
	logic [BW-1:0]        idx_n;
	logic [CPX_W-1:0]     l_n;
	logic [CPX_W-1:0]     p_n;
	logic [CPX_W-1:0]     r_n;
	logic                 edge_n;

	always_comb begin
		sq_re = in_re * in_re;
		sq_im = in_im * in_im;
	end

	always_comb begin
		len_raw = CW'(vector_len);
		if (len_raw == '0) begin
			len_eff = CW'(1);
		end else if (len_raw > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = len_raw;
		end
		cnt_inc = CW'(cnt_q) + CW'(1);
		is_last = (cnt_inc >= len_eff);
	end

	always_comb begin
		pw     = pre_s1 + pim_s1;
		cur    = {im_s1, re_s1};
		take   = (cnt_q == '0) || (pw > best_q);
		commit = v_s1 && (!is_last || !job_full);
		in_ready = !v_s1 || commit;

		idx_n  = take ? cnt_q : bidx_q;
		l_n    = take ? prev_q : left_q;
		p_n    = take ? cur : peak_q;
		r_n    = (!take && rpend_q) ? cur : right_q;
		edge_n = (idx_n == '0) || (idx_n == cnt_q);

		job_push = commit && is_last;
		job_data = {edge_n, idx_n, r_n, p_n, l_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			cnt_q   <= '0;
			rpend_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (commit) begin
				cnt_q   <= is_last ? '0 : cnt_inc[BW-1:0];
				rpend_q <= take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			re_s1  <= in_re;
			im_s1  <= in_im;
			pre_s1 <= sq_re;
			pim_s1 <= sq_im;
		end
		if (commit) begin
			prev_q <= cur;
			if (take) begin
				best_q <= pw;
				bidx_q <= cnt_q;
				peak_q <= cur;
				left_q <= prev_q;
			end else if (rpend_q) begin
				right_q <= cur;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/spi_back.sv =====
// Back end: sequenced Jacobsen offset on one shared multiplier and a restoring divider.
`default_nettype none

module spi_back #(
	parameter int MAX_VECTOR_LEN = spi_pkg::MAX_VECTOR_LEN_DEF,
	parameter int SAMPLE_WIDTH   = spi_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_empty,
	output logic                job_pop,
	input  logic [6*SAMPLE_WIDTH+$clog2(MAX_VECTOR_LEN):0] job_data,
	output logic                out_valid,
	input  logic                out_ready,
	output spi_pkg::result_t    out_result
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int BW     = $clog2(MAX_VECTOR_LEN);
	localparam int CPX_W  = 2 * SW;
	localparam int DW     = SW + 2;
	localparam int MW     = 2 * DW;
	localparam int DSUM_W = MW + 1;
	localparam int XW     = MW + 2 + spi_pkg::QUO_W;
	localparam int DCW    = $clog2(spi_pkg::QUO_W);

	spi_pkg::back_state_t state_q;
	spi_pkg::back_state_t state_d;

	logic [CPX_W-1:0] l_q;
	logic [CPX_W-1:0] p_q;
	logic [CPX_W-1:0] r_q;
	logic [BW-1:0]    idx_q;
	logic             edge_q;

	logic [DW-1:0]  nr_mag_q;
	logic [DW-1:0]  ni_mag_q;
	logic [DW-1:0]  dr_mag_q;
	logic [DW-1:0]  di_mag_q;
	logic           s_nr_q;
	logic           s_ni_q;
	logic           s_dr_q;
	logic           s_di_q;
	logic           dz_q;
	logic           forced_q;
	logic [MW-1:0]  prod_q;
	logic [DSUM_W-1:0] d_q;
	logic [MW-1:0]  m1_q;
	logic [DSUM_W-1:0] nmag_q;
	logic           neg_q;
	logic [XW-1:0]  rem_q;
	logic [XW-1:0]  t_q;
	logic [spi_pkg::QUO_W-1:0] q_q;
	logic [DCW-1:0] div_cnt_q;

	logic             out_valid_q;
	spi_pkg::result_t result_q;

	logic signed [SW-1:0] l_re, l_im, p_re, p_im, r_re, r_im;
	logic signed [DW-1:0] nr_x, ni_x, dr_x, di_x;
	logic [DW-1:0]        nr_mag, ni_mag, dr_mag, di_mag;
	logic [DW-1:0]        mul_a;
	logic [DW-1:0]        mul_b;
	logic                 s1, s2;
	logic [DSUM_W-1:0]    nmag;
	logic                 neg;
	logic                 ge;
	logic                 out_load;
	logic [spi_pkg::OFFSET_W-1:0] off;
	logic [BW+spi_pkg::PEAK_BIN_W-1:0] idx_ext;

	// differences of the captured neighbors
	always_comb begin
		l_re = l_q[SW-1:0];
		l_im = l_q[CPX_W-1:SW];
		p_re = p_q[SW-1:0];
		p_im = p_q[CPX_W-1:SW];
		r_re = r_q[SW-1:0];
		r_im = r_q[CPX_W-1:SW];
		nr_x = DW'(r_re) - DW'(l_re);
		ni_x = DW'(r_im) - DW'(l_im);
		dr_x = (DW'(p_re) <<< 1) - DW'(l_re) - DW'(r_re);
		di_x = (DW'(p_im) <<< 1) - DW'(l_im) - DW'(r_im);
		nr_mag = nr_x[DW-1] ? -nr_x : nr_x;
		ni_mag = ni_x[DW-1] ? -ni_x : ni_x;
		dr_mag = dr_x[DW-1] ? -dr_x : dr_x;
		di_mag = di_x[DW-1] ? -di_x : di_x;
	end

	// shared multiplier operands
	always_comb begin
		case (state_q)
			spi_pkg::B_MUL_II: begin
				mul_a = di_mag_q;
				mul_b = di_mag_q;
			end
			spi_pkg::B_MUL_ND: begin
				mul_a = nr_mag_q;
				mul_b = dr_mag_q;
			end
			spi_pkg::B_MUL_NI: begin
				mul_a = ni_mag_q;
				mul_b = di_mag_q;
			end
			default: begin
				mul_a = dr_mag_q;
				mul_b = dr_mag_q;
			end
		endcase
	end

	// signed numerator Re(conj-free) = nr*dr + ni*di, as magnitude and sign
	always_comb begin
		s1 = s_nr_q ^ s_dr_q;
		s2 = s_ni_q ^ s_di_q;
		if (s1 == s2) begin
			nmag = DSUM_W'(m1_q) + DSUM_W'(prod_q);
			neg  = s1;
		end else if (m1_q >= prod_q) begin
			nmag = DSUM_W'(m1_q - prod_q);
			neg  = s1;
		end else begin
			nmag = DSUM_W'(prod_q - m1_q);
			neg  = s2;
		end
		ge = (rem_q >= t_q);
	end

	always_comb begin
		if (forced_q) begin
			off = '0;
		end else if (neg_q) begin
			off = (q_q > spi_pkg::NEG_LIMIT) ? spi_pkg::OFFSET_MIN
				: spi_pkg::OFFSET_W'(spi_pkg::QUO_W'(0) - q_q);
		end else begin
			off = (q_q > spi_pkg::POS_LIMIT) ? spi_pkg::OFFSET_MAX
				: spi_pkg::OFFSET_W'(q_q);
		end
		idx_ext = {{spi_pkg::PEAK_BIN_W{1'b0}}, idx_q};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			spi_pkg::B_IDLE:   if (!job_empty) state_d = spi_pkg::B_DIFF;
			spi_pkg::B_DIFF:   state_d = edge_q ? spi_pkg::B_DONE : spi_pkg::B_MUL_DD;
			spi_pkg::B_MUL_DD: state_d = dz_q ? spi_pkg::B_DONE : spi_pkg::B_MUL_II;
			spi_pkg::B_MUL_II: state_d = spi_pkg::B_MUL_ND;
			spi_pkg::B_MUL_ND: state_d = spi_pkg::B_MUL_NI;
			spi_pkg::B_MUL_NI: state_d = spi_pkg::B_COMB;
			spi_pkg::B_COMB:   state_d = spi_pkg::B_PREP;
			spi_pkg::B_PREP:   state_d = spi_pkg::B_DIV;
			spi_pkg::B_DIV:    if (div_cnt_q == '0) state_d = spi_pkg::B_DONE;
			spi_pkg::B_DONE:   if (!out_valid_q || out_ready) state_d = spi_pkg::B_IDLE;
			default:           state_d = spi_pkg::B_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		job_pop  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			spi_pkg::B_IDLE: job_pop  = !job_empty;
			spi_pkg::B_DONE: out_load = !out_valid_q || out_ready;
			default: begin
				job_pop  = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spi_pkg::B_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == spi_pkg::B_PREP) begin
				div_cnt_q <= DCW'(spi_pkg::QUO_W - 1);
			end else if (state_q == spi_pkg::B_DIV) begin
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			spi_pkg::B_IDLE: begin
				if (job_pop) begin
					l_q    <= job_data[CPX_W-1:0];
					p_q    <= job_data[2*CPX_W-1:CPX_W];
					r_q    <= job_data[3*CPX_W-1:2*CPX_W];
					idx_q  <= job_data[3*CPX_W+BW-1:3*CPX_W];
					edge_q <= job_data[3*CPX_W+BW];
				end
			end
			spi_pkg::B_DIFF: begin
				nr_mag_q <= nr_mag;
				ni_mag_q <= ni_mag;
				dr_mag_q <= dr_mag;
				di_mag_q <= di_mag;
				s_nr_q   <= nr_x[DW-1];
				s_ni_q   <= ni_x[DW-1];
				s_dr_q   <= dr_x[DW-1];
				s_di_q   <= di_x[DW-1];
				dz_q     <= (dr_x == '0) && (di_x == '0);
				forced_q <= edge_q;
			end
			spi_pkg::B_MUL_DD: begin
				prod_q <= mul_a * mul_b;
				if (dz_q) begin
					forced_q <= 1'b1;
				end
			end
			spi_pkg::B_MUL_II: begin
				prod_q <= mul_a * mul_b;
				d_q    <= DSUM_W'(prod_q);
			end
			spi_pkg::B_MUL_ND: begin
				prod_q <= mul_a * mul_b;
				d_q    <= d_q + DSUM_W'(prod_q);
			end
			spi_pkg::B_MUL_NI: begin
				prod_q <= mul_a * mul_b;
				m1_q   <= prod_q;
			end
			spi_pkg::B_COMB: begin
				nmag_q <= nmag;
				neg_q  <= !neg;
			end
			spi_pkg::B_PREP: begin
				rem_q <= (XW'(nmag_q) << spi_pkg::FRAC_SHIFT) + XW'(d_q);
				t_q   <= XW'(d_q) << spi_pkg::QUO_W;
				q_q   <= '0;
			end
			spi_pkg::B_DIV: begin
				if (ge) begin
					rem_q <= rem_q - t_q;
				end
				q_q <= {q_q[spi_pkg::QUO_W-2:0], ge};
				t_q <= t_q >> 1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			result_q.peak_bin           <= idx_ext[spi_pkg::PEAK_BIN_W-1:0];
			result_q.frac_offset        <= off;
			result_q.offset_forced_zero <= forced_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = result_q;

endmodule

`default_nettype wire

// ===== rtl/core/spectral_peak_interpolator.sv =====
// Top level of the spectral peak interpolator (Jacobsen frequency estimator).
// Accepts one complex bin per clock on the slave stream; vector_len bins (0 acts as 1,
// values above MAX_VECTOR_LEN clamp to it) form one vector, and each vector yields one
// master transaction with the peak bin, the signed Q2.13 Jacobsen offset and a flag set
// when the offset was forced to zero (edge peak or zero denominator). The front end
// squares and compares one bin per clock; a two-entry job queue hands each finished
// vector to the back end, which works out the offset in a sequence of states on one shared
// multiplier and a one-bit-per-cycle divider. Short vectors can therefore hold off input
// once the queue is full; long vectors stream at one bin per clock. The result sits in
// an output register, and configuration writes take effect on the next bin.
`default_nettype none
`include "spectral_peak_interpolator_assert.svh"

module spectral_peak_interpolator #(
	parameter int MAX_VECTOR_LEN = spi_pkg::MAX_VECTOR_LEN_DEF,
	parameter int SAMPLE_WIDTH   = spi_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spi_pkg::VLEN_W-1:0]       cfg_wdata,    // vector_len
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // sample_re, sample_im
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [spi_pkg::OUT_TDATA_W-1:0]  m_tdata,      // peak_bin, frac_offset
	output logic                             m_tuser       // offset_forced_zero
);

	localparam int JOB_W = 6 * SAMPLE_WIDTH + $clog2(MAX_VECTOR_LEN) + 1;

	logic [spi_pkg::VLEN_W-1:0] vlen_q;
	logic                       job_push;
	logic                       job_pop;
	logic                       job_full;
	logic                       job_empty;
	logic [JOB_W-1:0]           job_wr;
	logic [JOB_W-1:0]           job_rd;
	spi_pkg::result_t           result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= spi_pkg::VLEN_RESET;
		end else if (cfg_we) begin
			vlen_q <= cfg_wdata;
		end
	end

	spi_front #(
		.MAX_VECTOR_LEN (MAX_VECTOR_LEN),
		.SAMPLE_WIDTH   (SAMPLE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vector_len (vlen_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_re      (s_tdata[SAMPLE_WIDTH-1:0]),
		.in_im      (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
		.job_push   (job_push),
		.job_data   (job_wr),
		.job_full   (job_full)
	);

	spi_job_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (spi_pkg::JOB_FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data (job_wr),
		.full    (job_full),
		.pop     (job_pop),
		.rd_data (job_rd),
		.empty   (job_empty)
	);

	spi_back #(
		.MAX_VECTOR_LEN (MAX_VECTOR_LEN),
		.SAMPLE_WIDTH   (SAMPLE_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_empty  (job_empty),
		.job_pop    (job_pop),
		.job_data   (job_rd),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = spi_pkg::OUT_TDATA_W'({result.frac_offset, result.peak_bin});
	assign m_tuser = result.offset_forced_zero;

	`SPI_ASSERT_IMPLIES(a_no_push_when_full, clk, arst_n, job_push, !job_full)
	`SPI_ASSERT_IMPLIES(a_no_pop_when_empty, clk, arst_n, job_pop, !job_empty)
	`SPI_ASSERT_NEXT(a_push_leaves_job, clk, arst_n, job_push, !job_empty)
	`SPI_ASSERT_IMPLIES(a_forced_is_zero, clk, arst_n, m_tvalid && m_tuser, result.frac_offset == '0)

endmodule

`default_nettype wire

// ===== test/tb_spectral_peak_interpolator.sv =====
// Self-checking testbench for the spectral peak interpolator stream block.
`timescale 1ns / 1ps

module tb_spectral_peak_interpolator;

	import spi_pkg::*;

	localparam int MAX_LEN      = MAX_VECTOR_LEN_DEF;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PAD_LSB      = PEAK_BIN_W + OFFSET_W;

	typedef struct {
		shortint re;
		shortint im;
	} bin_sample_t;

	typedef enum int {
		VK_SHAPED,
		VK_FULL,
		VK_TINY,
		VK_EXTREME
	} vec_kind_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [VLEN_W-1:0]      cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [31:0]            s_tdata = '0;     // sample_re, sample_im
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;          // peak_bin, frac_offset
	logic                   m_tuser;          // offset_forced_zero

	spectral_peak_interpolator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	// peak tracker state, mirrors the block after reset
	logic [VLEN_W-1:0] vlen_reg = VLEN_RESET;
	int unsigned       bin_cnt = 0;
	longint unsigned   best_pw = 0;
	int unsigned       best_idx = 0;
	bin_sample_t       prev_s = '{0, 0};
	bin_sample_t       left_s = '{0, 0};
	bin_sample_t       peak_s = '{0, 0};
	bin_sample_t       right_s = '{0, 0};
	bit                right_wanted = 1'b0;

	result_t     expected_reports[$];
	int unsigned mismatches = 0;
	int unsigned cycle_cnt = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned stall_request = 0;
	int unsigned stall_left = 0;

	// -Re((R-L)/(2P-L-R)) in Q2.13, round half away from zero, saturated
	function automatic logic [OFFSET_W-1:0] jacobsen_q13(input bin_sample_t l,
			input bin_sample_t p, input bin_sample_t r, output bit zero_den);
		longint nr, ni, dr, di, num, den, q;
		nr = longint'(r.re) - l.re;
		ni = longint'(r.im) - l.im;
		dr = 2 * longint'(p.re) - l.re - r.re;
		di = 2 * longint'(p.im) - l.im - r.im;
		zero_den = (dr == 0 && di == 0);
		if (zero_den)
			return '0;
		den = dr * dr + di * di;
		num = nr * dr + ni * di;
		q = ((num < 0 ? -num : num) * (longint'(1) << FRAC_SHIFT) + den) / (2 * den);
		if (num > 0)
			return (q > 32768) ? OFFSET_MIN : OFFSET_W'(-q);
		return (q > 32767) ? OFFSET_MAX : OFFSET_W'(q);
	endfunction

	// advance the tracker by one bin; returns 1 when the bin closes a vector
	function automatic bit track_bin(input bin_sample_t cur, output result_t rep);
		int unsigned     len_eff;
		int unsigned     idx;
		longint unsigned pw;
		bit              zero_den;
		len_eff = (vlen_reg == 0) ? 1 : int'(vlen_reg);
		if (len_eff > MAX_LEN)
			len_eff = MAX_LEN;
		idx = bin_cnt;
		pw = longint'(cur.re) * cur.re + longint'(cur.im) * cur.im;
		rep = '0;
		if (idx == 0 || pw > best_pw) begin
			best_pw = pw;
			best_idx = idx;
			peak_s = cur;
			left_s = prev_s;
			right_wanted = 1'b1;
		end else if (right_wanted) begin
			right_s = cur;
			right_wanted = 1'b0;
		end
		prev_s = cur;
		if (idx + 1 < len_eff) begin
			bin_cnt = idx + 1;
			return 1'b0;
		end
		bin_cnt = 0;
		rep.peak_bin = best_idx[PEAK_BIN_W-1:0];
		if (best_idx == 0 || best_idx == idx) begin
			rep.offset_forced_zero = 1'b1;
		end else begin
			rep.frac_offset = jacobsen_q13(left_s, peak_s, right_s, zero_den);
			rep.offset_forced_zero = zero_den;
		end
		return 1'b1;
	endfunction

	function automatic int noise(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic shortint pick_extreme();
		case ($urandom_range(5))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			default: return 32767;
		endcase
	endfunction

	task automatic send_sample(input shortint re, input shortint im);
		bin_sample_t cur;
		result_t     rep;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {im, re};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		cur.re = re;
		cur.im = im;
		if (track_bin(cur, rep))
			expected_reports.push_back(rep);
		@(negedge clk);
	endtask

	task automatic send_vector(input int unsigned len, input vec_kind_t kind);
		int unsigned pk;
		int          amp_re, amp_im, k;
		shortint     re, im;
		pk = $urandom_range(len - 1, 0);
		amp_re = int'($urandom_range(40000)) - 20000;
		amp_im = int'($urandom_range(40000)) - 20000;
		k = $urandom_range(15, 4);
		for (int unsigned b = 0; b < len; b++) begin
			case (kind)
				VK_SHAPED: begin
					if (b == pk) begin
						re = shortint'(amp_re);
						im = shortint'(amp_im);
					end else if (b + 1 == pk || b == pk + 1) begin
						re = shortint'(amp_re * k / 16 + noise(200));
						im = shortint'(amp_im * k / 16 + noise(200));
					end else begin
						re = shortint'(noise(500));
						im = shortint'(noise(500));
					end
				end
				VK_FULL: begin
					re = shortint'($urandom);
					im = shortint'($urandom);
				end
				VK_TINY: begin
					re = shortint'(noise(3));
					im = shortint'(noise(3));
				end
				default: begin
					re = pick_extreme();
					im = pick_extreme();
				end
			endcase
			send_sample(re, im);
		end
	endtask

	// pause input until every pending report is out, then let the back end settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_vector_len(input logic [VLEN_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		vlen_reg = v;
	endtask

	task automatic set_length(input logic [VLEN_W-1:0] v);
		wait_idle();
		write_vector_len(v);
	endtask

	// full-length vector with the length left at its reset value
	task automatic test_reset_length();
		send_vector(MAX_LEN, VK_SHAPED);
	endtask

	// zero acts as one, oversized values clamp to the maximum
	task automatic test_length_limits();
		set_length('0);
		send_sample(-32768, 32767);
		send_sample(12, -7);
		set_length(VLEN_W'(1));
		send_sample(-32768, -32768);
		send_sample(32767, 32767);
		send_sample(0, 0);
		set_length('1);
		send_vector(MAX_LEN, VK_FULL);
	endtask

	task automatic test_ties_and_edges();
		set_length(VLEN_W'(4));
		// all bins tie: first bin wins, edge
		send_sample(3, 4);
		send_sample(4, 3);
		send_sample(-5, 0);
		send_sample(0, 5);
		// tie after an interior peak keeps the earlier bin
		send_sample(1, 0);
		send_sample(3, 4);
		send_sample(5, 0);
		send_sample(2, 2);
		// peak on the last bin
		send_sample(1, 1);
		send_sample(2, 2);
		send_sample(3, 3);
		send_sample(9, 9);
	endtask

	// neighbors close to the peak on its circle drive the offset past +-4
	task automatic test_saturation();
		set_length(VLEN_W'(3));
		send_sample(29840, 2994);
		send_sample(30000, 0);
		send_sample(29894, -2397);
		send_sample(29894, 2397);
		send_sample(30000, 0);
		send_sample(29840, -2994);
	endtask

	// shrink the length below the bin count: the next bin closes the vector
	task automatic test_length_change_midvector();
		set_length(VLEN_W'(8));
		send_sample(100, 50);
		send_sample(900, -300);
		send_sample(2000, 1000);
		send_sample(700, 800);
		send_sample(-40, 10);
		set_length(VLEN_W'(3));
		send_sample(5, 5);
	endtask

	// output held off long enough to fill the job queue and stall the input
	task automatic test_backpressure();
		set_length(VLEN_W'(2));
		src_idle_pct = 0;
		sink_idle_pct = 0;
		stall_request = 400;
		for (int v = 0; v < 50; v++)
			send_vector(2, ($urandom_range(1) != 0) ? VK_FULL : VK_SHAPED);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
			input int unsigned n_items);
		int unsigned sent, len, nvec, r;
		vec_kind_t   kind;
		sent = 0;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 60)
				len = $urandom_range(8, 1);
			else if (r < 90)
				len = $urandom_range(40, 9);
			else
				len = $urandom_range(150, 41);
			set_length(VLEN_W'(len));
			nvec = $urandom_range(5, 1);
			for (int unsigned v = 0; v < nvec; v++) begin
				r = $urandom_range(99);
				if (r < 45)
					kind = VK_SHAPED;
				else if (r < 75)
					kind = VK_FULL;
				else if (r < 90)
					kind = VK_TINY;
				else
					kind = VK_EXTREME;
				send_vector(len, kind);
				sent += len;
			end
		end
	endtask

	// receiver: random ready, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (stall_request != 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// compare each output transaction against the oldest pending report
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected output transaction: tdata %h tuser %b", m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				if (m_tdata[PEAK_BIN_W-1:0] !== want.peak_bin) begin
					$error("peak_bin: expected %0d, got %0d", want.peak_bin,
						m_tdata[PEAK_BIN_W-1:0]);
					mismatches++;
				end
				if (m_tdata[PEAK_BIN_W +: OFFSET_W] !== want.frac_offset) begin
					$error("frac_offset: expected %0d, got %0d", $signed(want.frac_offset),
						$signed(m_tdata[PEAK_BIN_W +: OFFSET_W]));
					mismatches++;
				end
				if (m_tuser !== want.offset_forced_zero) begin
					$error("offset_forced_zero: expected %0b, got %0b",
						want.offset_forced_zero, m_tuser);
					mismatches++;
				end
				if ((m_tdata >> PAD_LSB) !== '0) begin
					$error("tdata padding: expected 0, got %0h", m_tdata >> PAD_LSB);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("** spectral_peak_interpolator: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_length();
		test_length_limits();
		test_ties_and_edges();
		test_saturation();
		test_length_change_midvector();
		test_backpressure();
		test_random_traffic(33, 70, 270);
		test_random_traffic(70, 33, 270);
		test_random_traffic(0, 0, 270);
		wait_idle();

		if (mismatches == 0)
			$display("** spectral_peak_interpolator: PASSED **");
		else
			$display("** spectral_peak_interpolator: FAILED **");
		$finish;
	end

endmodule

// ===== spectral_peak_interpolator.f =====
+incdir+rtl/core
rtl/core/spi_pkg.sv
rtl/core/spi_job_fifo.sv
rtl/core/spi_front.sv
rtl/core/spi_back.sv
rtl/core/spectral_peak_interpolator.sv
test/tb_spectral_peak_interpolator.sv
